/* hdl/timed_parameter_ramp_assert.svh */
`ifndef TIMED_PARAMETER_RAMP_ASSERT_SVH
`define TIMED_PARAMETER_RAMP_ASSERT_SVH

// same-cycle check, reset masks it
`define TPR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle check, reset masks it
`define TPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/tpr_pkg.sv */
package tpr_pkg;

  localparam int REPORTED = 6;

  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_SET  = 1'b1;

  typedef struct packed {
    logic               action;
    logic [2:0]         param_index;
    logic signed [15:0] target_level;
    logic [15:0]        ramp_ticks;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] volume_level;
    logic signed [15:0] bend_level;
    logic signed [15:0] fx_level;
    logic signed [15:0] pan_level;
    logic signed [15:0] surround_level;
    logic signed [15:0] distance_level;
    logic [5:0]         ramping_mask;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_PUBLISH
  } state_t;

  typedef struct packed {
    logic set_en;
    logic step_en;
  } bank_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* hdl/tpr_div.sv */
module tpr_div #(
  parameter int DW = 17
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic signed [DW-1:0]  dividend,
  input  logic [15:0]           divisor,
  output tpr_pkg::div_stat_t    stat,
  output logic signed [DW-1:0]  quot
);
  import tpr_pkg::*;

  localparam int CNW = $clog2(DW + 1);

  logic [DW-1:0]  q_r;
  logic [15:0]    rem_r;
  logic [15:0]    d_r;
  logic           neg_r;
  logic [CNW-1:0] cnt_r;
  logic           busy_r;
  logic           done_r;

  logic [DW-1:0]  mag;
  logic [16:0]    trial;
  logic           ge;
  logic [15:0]    rem_nxt;
  logic [DW-1:0]  q_nxt;

  assign mag     = dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
  assign trial   = {rem_r, q_r[DW-1]};
  assign ge      = trial >= {1'b0, d_r};
  assign rem_nxt = ge ? 16'(trial - {1'b0, d_r}) : trial[15:0];
  assign q_nxt   = {q_r[DW-2:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNW'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNW'(1);
        if (cnt_r == CNW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= mag;
      rem_r <= '0;
      d_r   <= divisor;
      neg_r <= dividend[DW-1];
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quot      = neg_r ? -signed'(q_r) : signed'(q_r);
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

/* hdl/tpr_bank.sv */
module tpr_bank #(
  parameter int NUM_ENTRIES = 6,
  parameter int LEVEL_BITS  = 16,
  localparam int LW = (LEVEL_BITS > 16) ? LEVEL_BITS : 16,
  localparam int DW = LW + 1,
  localparam int IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  tpr_pkg::bank_ctl_t      ctl,
  input  logic [2:0]              set_index,
  input  logic signed [15:0]      set_target,
  input  logic [15:0]             set_ticks,
  input  logic [IW-1:0]           step_index,
  input  logic signed [DW-1:0]    step_quot,
  output logic signed [LW-1:0]    cur_level,
  output logic signed [LW-1:0]    cur_target,
  output logic [15:0]             cur_remaining,
  output logic signed [LW-1:0]    levels [NUM_ENTRIES],
  output logic [NUM_ENTRIES-1:0]  ramping
);
  import tpr_pkg::*;

  localparam logic signed [LW-1:0] Q_ONE  = LW'(64'sd1 <<< (LEVEL_BITS - 2));
  localparam logic signed [LW-1:0] Q_HALF = LW'(64'sd1 <<< (LEVEL_BITS - 3));

  logic signed [LW-1:0] level_r     [NUM_ENTRIES];
  logic signed [LW-1:0] target_r    [NUM_ENTRIES];
  logic [15:0]          remaining_r [NUM_ENTRIES];
  logic signed [LW-1:0] set_value;

  assign set_value = LW'(set_target);

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (!rst_n) begin
        level_r[i]     <= (i == 0) ? Q_ONE : (i == 3) ? Q_HALF : '0;
        target_r[i]    <= (i == 0) ? Q_ONE : (i == 3) ? Q_HALF : '0;
        remaining_r[i] <= '0;
      end else if (ctl.set_en && int'(set_index) == i) begin
        target_r[i]    <= set_value;
        remaining_r[i] <= set_ticks;
        if (set_ticks == '0) begin
          level_r[i] <= set_value;
        end
      end else if (ctl.step_en && int'(step_index) == i) begin
        level_r[i]     <= LW'(DW'(level_r[i]) + step_quot);
        remaining_r[i] <= remaining_r[i] - 16'd1;
      end
    end
  end

  assign cur_level     = level_r[step_index];
  assign cur_target    = target_r[step_index];
  assign cur_remaining = remaining_r[step_index];

  always_comb begin
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      levels[i]  = level_r[i];
      ramping[i] = remaining_r[i] != '0;
    end
  end

endmodule

/* hdl/timed_parameter_ramp.sv */
// Channel  | Handshake             | Payload
// in       | in_valid / in_stall   | in_data  (tpr_pkg::in_item_t)
// out      | out_valid / out_stall | out_data (tpr_pkg::out_item_t)
//
// A set item updates its entry when the index is in range, then publishes. A tick item
// scans every entry and, for each ramping entry, runs the serial divider, one quotient
// bit a cycle, on target minus level over the remaining ticks, then steps the level.
// in_stall is high from accept until the result enters the output register.
// A stalled result holds in the output register while the next item is taken.
// rst_n is synchronous and restores the reset levels and clears all ramps.
module timed_parameter_ramp #(
  parameter int NUM_ENTRIES = 6,
  parameter int LEVEL_BITS  = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tpr_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tpr_pkg::out_item_t  out_data
);
  import tpr_pkg::*;

  `include "timed_parameter_ramp_assert.svh"

  localparam int LW = (LEVEL_BITS > 16) ? LEVEL_BITS : 16;
  localparam int DW = LW + 1;
  localparam int IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int CW = $clog2(NUM_ENTRIES + 1);

  state_t               state_r, state_nxt;
  logic [CW-1:0]        ent_r, ent_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r;

  bank_ctl_t            ctl;
  div_stat_t            div_stat;
  logic                 div_start;
  logic signed [DW-1:0] div_dividend;
  logic signed [DW-1:0] div_quot;
  logic                 in_accept;
  logic                 load_out;
  logic                 ent_done;

  logic signed [LW-1:0] cur_level;
  logic signed [LW-1:0] cur_target;
  logic [15:0]          cur_remaining;
  logic signed [LW-1:0] levels [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] ramping;

  logic signed [15:0]   rep_lvl [REPORTED];
  logic [REPORTED-1:0]  rep_mask;
  out_item_t            result;

  tpr_bank #(
    .NUM_ENTRIES (NUM_ENTRIES),
    .LEVEL_BITS  (LEVEL_BITS)
  ) u_bank (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .set_index     (in_data.param_index),
    .set_target    (in_data.target_level),
    .set_ticks     (in_data.ramp_ticks),
    .step_index    (ent_r[IW-1:0]),
    .step_quot     (div_quot),
    .cur_level     (cur_level),
    .cur_target    (cur_target),
    .cur_remaining (cur_remaining),
    .levels        (levels),
    .ramping       (ramping)
  );

  tpr_div #(
    .DW (DW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (cur_remaining),
    .stat     (div_stat),
    .quot     (div_quot)
  );

  assign in_stall     = state_r != ST_IDLE;
  assign in_accept    = in_valid && !in_stall;
  assign div_dividend = DW'(cur_target) - DW'(cur_level);
  assign ent_done     = int'(ent_r) >= NUM_ENTRIES;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ent_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ent_r       <= ent_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    ent_nxt     = ent_r;
    ctl.set_en  = 1'b0;
    ctl.step_en = 1'b0;
    div_start   = 1'b0;
    load_out    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_data.action == ACT_SET) begin
            ctl.set_en = int'(in_data.param_index) < NUM_ENTRIES;
            state_nxt  = ST_PUBLISH;
          end else begin
            ent_nxt   = '0;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (ent_done) begin
          state_nxt = ST_PUBLISH;
        end else if (cur_remaining != '0) begin
          div_start = 1'b1;
          state_nxt = ST_WAIT;
        end else begin
          ent_nxt = ent_r + CW'(1);
        end
      end
      ST_WAIT: begin
        if (div_stat.done) begin
          ctl.step_en = 1'b1;
          ent_nxt     = ent_r + CW'(1);
          state_nxt   = ST_SCAN;
        end
      end
      ST_PUBLISH: begin
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid_nxt = load_out ? 1'b1 : (out_valid_r && out_stall);

  for (genvar gi = 0; gi < REPORTED; gi++) begin : g_rep
    if (gi < NUM_ENTRIES) begin : g_on
      assign rep_lvl[gi]  = levels[gi][15:0];
      assign rep_mask[gi] = ramping[gi];
    end else begin : g_off
      assign rep_lvl[gi]  = '0;
      assign rep_mask[gi] = 1'b0;
    end
  end

  assign result.volume_level   = rep_lvl[0];
  assign result.bend_level     = rep_lvl[1];
  assign result.fx_level       = rep_lvl[2];
  assign result.pan_level      = rep_lvl[3];
  assign result.surround_level = rep_lvl[4];
  assign result.distance_level = rep_lvl[5];
  assign result.ramping_mask   = rep_mask;

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `TPR_ASSERT_NEXT(a_accept_busy, in_accept, state_r != ST_IDLE,
                   "accepted item left block idle")
  `TPR_ASSERT_NOW(a_done_in_wait, div_stat.done, state_r == ST_WAIT,
                  "divider finished outside wait")
  `TPR_ASSERT_NOW(a_start_free, div_start, !div_stat.busy && state_r == ST_SCAN,
                  "divider started while busy")
  `TPR_ASSERT_NEXT(a_publish, load_out, out_valid_r && state_r == ST_IDLE,
                   "result not loaded on publish")

endmodule

/* tb/sv/tb_timed_parameter_ramp.sv */
module tb_timed_parameter_ramp;
  import tpr_pkg::*;

  localparam int NUM_PARAMS   = 6;
  localparam int RANDOM_ITEMS = 1700;
  localparam int DRAIN_CYCLES = 150;
  localparam int REPORT_LIMIT = 10;
  localparam int DRAIN_EVERY  = 500;
  localparam int NUM_FIELDS   = 7;

  localparam logic [2:0] PRM_VOLUME   = 3'd0;
  localparam logic [2:0] PRM_BEND     = 3'd1;
  localparam logic [2:0] PRM_FX       = 3'd2;
  localparam logic [2:0] PRM_PAN      = 3'd3;
  localparam logic [2:0] PRM_SURROUND = 3'd4;
  localparam logic [2:0] PRM_DISTANCE = 3'd5;
  localparam logic [2:0] PRM_SPARE_LO = 3'd6;
  localparam logic [2:0] PRM_SPARE_HI = 3'd7;

  typedef enum int {
    STALL_NONE,
    STALL_COIN,
    STALL_HEAVY,
    STALL_BLOCKS
  } stall_mode_t;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  int level_now [NUM_PARAMS];
  int level_goal[NUM_PARAMS];
  int ticks_left[NUM_PARAMS];

  out_item_t   pending_levels[$];
  dir_row_t    directed_rows[$];
  int          fault_count = 0;
  int          results_seen = 0;
  int          tick_count = 0;
  int          set_count = 0;
  int          ignored_count = 0;
  int          burst_left = 0;
  int          stall_phase_left = 0;
  stall_mode_t stall_mode = STALL_NONE;

  timed_parameter_ramp i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic in_item_t mk_item(logic act, logic [2:0] idx, int tgt, int ticks);
    in_item_t it;
    it.action       = act;
    it.param_index  = idx;
    it.target_level = tgt[15:0];
    it.ramp_ticks   = ticks[15:0];
    return it;
  endfunction

  function automatic out_item_t mk_levels(int v0, int v1, int v2, int v3, int v4, int v5,
                                          logic [5:0] mask);
    out_item_t r;
    r.volume_level   = v0[15:0];
    r.bend_level     = v1[15:0];
    r.fx_level       = v2[15:0];
    r.pan_level      = v3[15:0];
    r.surround_level = v4[15:0];
    r.distance_level = v5[15:0];
    r.ramping_mask   = mask;
    return r;
  endfunction

  function automatic void reset_ramp_levels();
    level_now  = '{16384, 0, 0, 8192, 0, 0};
    level_goal = '{16384, 0, 0, 8192, 0, 0};
    ticks_left = '{0, 0, 0, 0, 0, 0};
  endfunction

  // advance the level table by one item and report all levels
  function automatic out_item_t ramp_predict(in_item_t it);
    out_item_t  r;
    int         d;
    logic [5:0] mask;
    if (it.action == ACT_SET) begin
      if (it.param_index < NUM_PARAMS) begin
        level_goal[it.param_index] = int'($signed(it.target_level));
        if (it.ramp_ticks == 16'd0) begin
          level_now[it.param_index] = level_goal[it.param_index];
        end
        ticks_left[it.param_index] = int'(it.ramp_ticks);
      end
    end else begin
      for (int i = 0; i < NUM_PARAMS; i++) begin
        if (ticks_left[i] != 0) begin
          d = level_goal[i] - level_now[i];
          level_now[i] = level_now[i] + d / ticks_left[i];
          ticks_left[i] = ticks_left[i] - 1;
        end
      end
    end
    for (int i = 0; i < NUM_PARAMS; i++) begin
      mask[i] = (ticks_left[i] != 0);
    end
    r = mk_levels(level_now[0], level_now[1], level_now[2], level_now[3], level_now[4],
                  level_now[5], mask);
    return r;
  endfunction

  function automatic logic [15:0] field_of(out_item_t r, int k);
    case (k)
      0:       return r.volume_level;
      1:       return r.bend_level;
      2:       return r.fx_level;
      3:       return r.pan_level;
      4:       return r.surround_level;
      5:       return r.distance_level;
      default: return {10'd0, r.ramping_mask};
    endcase
  endfunction

  task automatic add_row(in_item_t it, bit typed, out_item_t want);
    dir_row_t row;
    row.item  = it;
    row.typed = typed;
    row.want  = want;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  task automatic send_item(in_item_t it, bit typed, out_item_t want);
    out_item_t predicted;
    in_data  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    predicted = ramp_predict(it);
    pending_levels.insert(pending_levels.size(), typed ? want : predicted);
    if (it.action == ACT_TICK) begin
      tick_count++;
    end else if (it.param_index < NUM_PARAMS) begin
      set_count++;
    end else begin
      ignored_count++;
    end
  endtask

  // bursts of random length separated by random gaps
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (stall_phase_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_phase_left = $urandom_range(16, 240);
    end
    stall_phase_left--;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_COIN:  out_stall <= ($urandom_range(0, 1) == 1);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 7) != 0);
      default:     out_stall <= ((stall_phase_left % 24) < 9);
    endcase
  end

  always @(posedge clk) begin
    out_item_t want;
    int        bad;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_levels.size() == 0) begin
        fault_count++;
        if (fault_count <= REPORT_LIMIT) begin
          $display("result %0d arrived with nothing pending: %h", results_seen, out_data);
        end
      end else begin
        want = pending_levels.pop_front();
        bad = 0;
        for (int k = 0; k < NUM_FIELDS; k++) begin
          if (field_of(want, k) !== field_of(out_data, k)) bad++;
        end
        if (bad != 0) begin
          fault_count++;
          if (fault_count <= REPORT_LIMIT) begin
            $display("result %0d: %0d field(s) wrong", results_seen, bad);
            $display("  expected vol %h bend %h fx %h pan %h sur %h dist %h mask %b",
                     want.volume_level, want.bend_level, want.fx_level, want.pan_level,
                     want.surround_level, want.distance_level, want.ramping_mask);
            $display("  actual   vol %h bend %h fx %h pan %h sur %h dist %h mask %b",
                     out_data.volume_level, out_data.bend_level, out_data.fx_level,
                     out_data.pan_level, out_data.surround_level, out_data.distance_level,
                     out_data.ramping_mask);
          end
        end
      end
    end
  end

  initial begin
    #30_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    in_item_t  it;
    out_item_t at_reset;
    int        random_done;
    int        pick;
    random_done = 0;
    reset_ramp_levels();
    at_reset = mk_levels(16384, 0, 0, 8192, 0, 0, 6'b000000);

    add_row(mk_item(ACT_TICK, PRM_SPARE_HI, 32767, 65535), 1'b1, at_reset);
    add_row(mk_item(ACT_SET, PRM_SPARE_LO, 1234, 5), 1'b1, at_reset);
    add_row(mk_item(ACT_SET, PRM_SPARE_HI, -32768, 65535), 1'b1, at_reset);
    add_row(mk_item(ACT_SET, PRM_VOLUME, 32767, 0), 1'b1,
            mk_levels(32767, 0, 0, 8192, 0, 0, 6'b000000));
    add_row(mk_item(ACT_SET, PRM_BEND, -32768, 0), 1'b1,
            mk_levels(32767, -32768, 0, 8192, 0, 0, 6'b000000));
    add_row(mk_item(ACT_SET, PRM_FX, 32767, 65535), 1'b1,
            mk_levels(32767, -32768, 0, 8192, 0, 0, 6'b000100));
    add_row(mk_item(ACT_SET, PRM_PAN, -32768, 1), 1'b1,
            mk_levels(32767, -32768, 0, 8192, 0, 0, 6'b001100));
    add_row(mk_item(ACT_TICK, PRM_VOLUME, 0, 0), 1'b0, '0);
    add_row(mk_item(ACT_SET, PRM_SURROUND, 100, 3), 1'b0, '0);
    add_row(mk_item(ACT_SET, PRM_DISTANCE, -100, 7), 1'b0, '0);
    add_row(mk_item(ACT_TICK, PRM_SPARE_LO, -1, 1), 1'b0, '0);
    add_row(mk_item(ACT_TICK, PRM_PAN, 21845, 43690), 1'b0, '0);
    add_row(mk_item(ACT_TICK, PRM_FX, -21846, 21845), 1'b0, '0);
    add_row(mk_item(ACT_SET, PRM_VOLUME, -32768, 65535), 1'b0, '0);
    add_row(mk_item(ACT_TICK, PRM_VOLUME, 0, 0), 1'b0, '0);
    add_row(mk_item(ACT_SET, PRM_BEND, 32767, 2), 1'b0, '0);
    add_row(mk_item(ACT_TICK, PRM_BEND, 0, 0), 1'b0, '0);
    add_row(mk_item(ACT_TICK, PRM_BEND, 0, 0), 1'b0, '0);
    add_row(mk_item(ACT_SET, PRM_FX, 0, 0), 1'b0, '0);
    add_row(mk_item(ACT_SET, PRM_DISTANCE, 1, 0), 1'b0, '0);
    add_row(mk_item(ACT_SET, PRM_SURROUND, -1, 65535), 1'b0, '0);
    add_row(mk_item(ACT_TICK, PRM_SURROUND, 0, 0), 1'b0, '0);
    add_row(mk_item(ACT_SET, PRM_VOLUME, 16384, 0), 1'b0, '0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[n]) begin
      pace();
      send_item(directed_rows[n].item, directed_rows[n].typed, directed_rows[n].want);
    end
    wait_for_drain();

    while (random_done < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      it.action       = ACT_TICK;
      it.param_index  = 3'($urandom);
      it.target_level = 16'($urandom);
      it.ramp_ticks   = 16'($urandom);
      if (pick >= 45 && pick < 90) begin
        it.action      = ACT_SET;
        it.param_index = 3'($urandom_range(0, NUM_PARAMS - 1));
        case ($urandom_range(0, 9))
          0: it.target_level = 16'sh7fff;
          1: it.target_level = 16'sh8000;
          2: it.target_level = 16'sh0000;
          default: it.target_level = 16'($urandom);
        endcase
        pick = $urandom_range(0, 19);
        if (pick < 3) begin
          it.ramp_ticks = 16'd0;
        end else if (pick < 14) begin
          it.ramp_ticks = 16'($urandom_range(1, 12));
        end else if (pick < 17) begin
          it.ramp_ticks = 16'($urandom_range(13, 300));
        end else if (pick < 19) begin
          it.ramp_ticks = 16'($urandom);
        end else begin
          it.ramp_ticks = 16'hffff;
        end
      end else if (pick >= 90 && pick < 96) begin
        it.action      = ACT_SET;
        it.param_index = ($urandom_range(0, 1) == 0) ? PRM_SPARE_LO : PRM_SPARE_HI;
      end
      pace();
      send_item(it, 1'b0, '0);
      random_done++;
      if (random_done % DRAIN_EVERY == 0) wait_for_drain();
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_levels.size() != 0) fault_count++;

    $display("covered %0d ticks, %0d sets and %0d out-of-range sets; %0d results compared",
             tick_count, set_count, ignored_count, results_seen);
    $display("%0d faulty results", fault_count);
    if (fault_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
